// File: src/aabb_query_unit_macros.svh
// ----------------------------------------------------------------------------
// AABB query unit assertion macros
// Shared property forms for the checker; clk and arst_n come from the scope.
// ----------------------------------------------------------------------------
`ifndef AABB_QUERY_UNIT_MACROS_SVH
`define AABB_QUERY_UNIT_MACROS_SVH

// same-cycle implication, off while in reset
`define AQU_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while in reset
`define AQU_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/aabbq_pkg.sv
// ----------------------------------------------------------------------------
// AABB query package
// Field widths, query and verdict codes, register indexes, stage enables.
// ----------------------------------------------------------------------------
package aabbq_pkg;

	localparam int FIELD_W     = 32;
	localparam int AXES        = 3;
	localparam int N_IN_DATA   = 7;
	localparam int IN_TDATA_W  = FIELD_W * N_IN_DATA;
	localparam int FUNC_W      = 2;
	localparam int VERDICT_W   = 3;
	localparam int OUT_TDATA_W = 8;
	localparam int CFG_IDX_W   = 3;
	localparam int FRAC_BITS   = 16;

	// query kinds
	localparam logic [FUNC_W-1:0] FUNC_POINT  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_BOX    = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_SPHERE = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_PLANE  = 2'd3;

	// verdicts
	localparam logic [VERDICT_W-1:0] VERDICT_DISJOINT     = 3'd0;
	localparam logic [VERDICT_W-1:0] VERDICT_CONTAINS     = 3'd1;
	localparam logic [VERDICT_W-1:0] VERDICT_INTERSECTS   = 3'd2;
	localparam logic [VERDICT_W-1:0] VERDICT_PLANE_FRONT  = 3'd3;
	localparam logic [VERDICT_W-1:0] VERDICT_PLANE_BACK   = 3'd4;
	localparam logic [VERDICT_W-1:0] VERDICT_PLANE_ISECT  = 3'd5;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_Z = 3'd5;

	// load enables for the two multiplier stages
	typedef struct packed {
		logic s3;
		logic s4;
	} stage_en_t;

endpackage

// File: src/aabbq_mul.sv
// ----------------------------------------------------------------------------
// AABB query multiplier
// Two-stage magnitude multiplier: half-width partial products, then merge
// and sign.
// ----------------------------------------------------------------------------
module aabbq_mul import aabbq_pkg::*; #(
	parameter int W = 32
) (
	input  logic                 clk,
	input  stage_en_t            en,
	input  logic [W-1:0]         a,
	input  logic [W-1:0]         b,
	input  logic                 neg,
	output logic signed [2*W:0]  p
);

	localparam int H   = (W + 1) / 2;
	localparam int PPW = 2 * H;
	localparam int FW  = 4 * H;
	localparam int PW  = 2 * W + 1;

	logic [H-1:0]   a_lo, a_hi, b_lo, b_hi;
	logic [PPW-1:0] ll_s3, lh_s3, hl_s3, hh_s3;
	logic           neg_s3;
	logic [FW-1:0]  mid, full;
	logic signed [PW-1:0] ext;
	logic signed [PW-1:0] p_s4;

	assign a_lo = a[H-1:0];
	assign a_hi = H'(a >> H);
	assign b_lo = b[H-1:0];
	assign b_hi = H'(b >> H);

	always_ff @(posedge clk) begin
		if (en.s3) begin
			ll_s3  <= PPW'(a_lo) * PPW'(b_lo);
			lh_s3  <= PPW'(a_lo) * PPW'(b_hi);
			hl_s3  <= PPW'(a_hi) * PPW'(b_lo);
			hh_s3  <= PPW'(a_hi) * PPW'(b_hi);
			neg_s3 <= neg;
		end
	end

	always_comb begin
		mid  = FW'(lh_s3) + FW'(hl_s3);
		full = {hh_s3, ll_s3} + (mid << H);
		ext  = {1'b0, full[2*W-1:0]};
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			p_s4 <= neg_s3 ? -ext : ext;
		end
	end

	assign p = p_s4;

endmodule

// File: src/aabb_query_unit.sv
// ----------------------------------------------------------------------------
// AABB query unit: turns each query word into one result word.
// Throughput one word per cycle when not stalled; six register stages, seven
// shared split multipliers, a stalled output back-pressures stage by stage.
// Reset clears the stage valids and sets every box bound to zero.
// ----------------------------------------------------------------------------
module aabb_query_unit import aabbq_pkg::*; #(
	parameter int COORD_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration write channel
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [FIELD_W-1:0]     cfg_data,
	// query words
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// first_x, first_y, first_z, second_x, second_y, second_z, scalar
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// func
	input  logic [FUNC_W-1:0]      s_tuser,
	// result words
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// verdict, zero padded to a byte
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	localparam int W    = COORD_BITS;
	localparam int PW   = 2 * W + 1;   // signed product
	localparam int SW   = 2 * W + 4;   // signed sum, room for six products
	localparam int NMUL = 2 * AXES + 1;

	// Stage map
	//   s1  capture word
	//   s2  bound compares, point/box verdict, multiplier operand select
	//   s3  partial products (in aabbq_mul)
	//   s4  merged, signed products (in aabbq_mul)
	//   s5  two three-term sums
	//   s6  offset add / sphere compare, final verdict

	// -- coordinate view: low COORD_BITS of a 32-bit field, two's complement
	function automatic logic signed [W-1:0] to_coord(input logic [FIELD_W-1:0] r);
		logic [2*FIELD_W-1:0] e;
		begin
			e = {{FIELD_W{1'b0}}, r};
			return e[W-1:0];
		end
	endfunction

	function automatic logic [W-1:0] mag(input logic signed [W-1:0] x);
		begin
			return x[W-1] ? (~x) + 1'b1 : x;
		end
	endfunction

	// -- box registers
	logic signed [W-1:0] box_lo_q [AXES];
	logic signed [W-1:0] box_hi_q [AXES];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AXES; i++) begin
				box_lo_q[i] <= '0;
				box_hi_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_BOX_MIN_X: box_lo_q[0] <= to_coord(cfg_data);
				CFG_BOX_MIN_Y: box_lo_q[1] <= to_coord(cfg_data);
				CFG_BOX_MIN_Z: box_lo_q[2] <= to_coord(cfg_data);
				CFG_BOX_MAX_X: box_hi_q[0] <= to_coord(cfg_data);
				CFG_BOX_MAX_Y: box_hi_q[1] <= to_coord(cfg_data);
				CFG_BOX_MAX_Z: box_hi_q[2] <= to_coord(cfg_data);
				default: ;     // indexes past the list are dropped
			endcase
		end
	end

	// -- handshake: each stage loads when empty or when the next one moves
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic adv1, adv2, adv3, adv4, adv5, adv6;

	assign adv6 = !vld_s6 || m_tready;
	assign adv5 = !vld_s5 || adv6;
	assign adv4 = !vld_s4 || adv5;
	assign adv3 = !vld_s3 || adv4;
	assign adv2 = !vld_s2 || adv3;
	assign adv1 = !vld_s1 || adv2;

	assign s_tready = adv1;
	assign m_tvalid = vld_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= s_tvalid;
			if (adv2) vld_s2 <= vld_s1;
			if (adv3) vld_s3 <= vld_s2;
			if (adv4) vld_s4 <= vld_s3;
			if (adv5) vld_s5 <= vld_s4;
			if (adv6) vld_s6 <= vld_s5;
		end
	end

	// -- s1: capture
	logic [IN_TDATA_W-1:0] tdata_s1;
	logic [FUNC_W-1:0]     func_s1;

	always_ff @(posedge clk) begin
		if (adv1) begin
			tdata_s1 <= s_tdata;
			func_s1  <= s_tuser;
		end
	end

	// -- s2 logic
	logic signed [W-1:0] pa [AXES];
	logic signed [W-1:0] pb [AXES];
	logic signed [W-1:0] rs;
	logic [W-1:0]        rmag;

	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			pa[i] = to_coord(tdata_s1[FIELD_W*i +: FIELD_W]);
			pb[i] = to_coord(tdata_s1[FIELD_W*(i+AXES) +: FIELD_W]);
		end
	end

	assign rs   = to_coord(tdata_s1[FIELD_W*(2*AXES) +: FIELD_W]);
	assign rmag = mag(rs);

	logic                below [AXES];
	logic                above [AXES];
	logic [W-1:0]        dlo   [AXES];
	logic [W-1:0]        dhi   [AXES];
	logic signed [W-1:0] vneg  [AXES];
	logic signed [W-1:0] vpos  [AXES];
	logic [W-1:0]        op_a  [NMUL];
	logic [W-1:0]        op_b  [NMUL];
	logic                sgn   [NMUL];
	logic                pt_in, apart, enclosed;
	logic [VERDICT_W-1:0] cls;

	always_comb begin
		pt_in    = 1'b1;
		apart    = 1'b0;
		enclosed = 1'b1;
		for (int i = 0; i < AXES; i++) begin
			below[i] = pa[i] < box_lo_q[i];
			above[i] = pa[i] > box_hi_q[i];
			pt_in    = pt_in && !below[i] && !above[i];
			apart    = apart || (pb[i] < box_lo_q[i]) || above[i];
			enclosed = enclosed && !below[i] && !(pb[i] > box_hi_q[i]);
			// excess past a bound, exact in W bits when that side is hit
			dlo[i]   = W'(box_lo_q[i] - pa[i]);
			dhi[i]   = W'(pa[i] - box_hi_q[i]);
			// negative vertex takes min for a non-negative normal component
			vneg[i]  = pa[i][W-1] ? box_hi_q[i] : box_lo_q[i];
			vpos[i]  = pa[i][W-1] ? box_lo_q[i] : box_hi_q[i];
			if (func_s1 == FUNC_SPHERE) begin
				// inverted box may hit both sides; both squares count
				op_a[i]      = below[i] ? dlo[i] : '0;
				op_b[i]      = below[i] ? dlo[i] : '0;
				sgn[i]       = 1'b0;
				op_a[i+AXES] = above[i] ? dhi[i] : '0;
				op_b[i+AXES] = above[i] ? dhi[i] : '0;
				sgn[i+AXES]  = 1'b0;
			end else begin
				op_a[i]      = mag(pa[i]);
				op_b[i]      = mag(vneg[i]);
				sgn[i]       = pa[i][W-1] ^ vneg[i][W-1];
				op_a[i+AXES] = mag(pa[i]);
				op_b[i+AXES] = mag(vpos[i]);
				sgn[i+AXES]  = pa[i][W-1] ^ vpos[i][W-1];
			end
		end
		// radius squared, sign of radius dropped
		op_a[2*AXES] = (func_s1 == FUNC_SPHERE) ? rmag : '0;
		op_b[2*AXES] = (func_s1 == FUNC_SPHERE) ? rmag : '0;
		sgn[2*AXES]  = 1'b0;

		if (func_s1 == FUNC_POINT)
			cls = pt_in ? VERDICT_CONTAINS : VERDICT_DISJOINT;
		else if (apart)
			cls = VERDICT_DISJOINT;
		else
			cls = enclosed ? VERDICT_CONTAINS : VERDICT_INTERSECTS;
	end

	// -- s2 registers
	logic [FUNC_W-1:0]    func_s2;
	logic [VERDICT_W-1:0] cls_s2;
	logic signed [W-1:0]  d_s2;
	logic [W-1:0]         op_a_s2 [NMUL];
	logic [W-1:0]         op_b_s2 [NMUL];
	logic                 sgn_s2  [NMUL];

	always_ff @(posedge clk) begin
		if (adv2) begin
			func_s2 <= func_s1;
			cls_s2  <= cls;
			d_s2    <= rs;
			for (int k = 0; k < NMUL; k++) begin
				op_a_s2[k] <= op_a[k];
				op_b_s2[k] <= op_b[k];
				sgn_s2[k]  <= sgn[k];
			end
		end
	end

	// -- s3/s4: multipliers, sideband travels alongside
	stage_en_t           mul_en;
	logic signed [PW-1:0] prod_s4 [NMUL];

	assign mul_en.s3 = adv3;
	assign mul_en.s4 = adv4;

	for (genvar k = 0; k < NMUL; k++) begin : g_mul
		aabbq_mul #(.W(W)) u_mul (
			.clk (clk),
			.en  (mul_en),
			.a   (op_a_s2[k]),
			.b   (op_b_s2[k]),
			.neg (sgn_s2[k]),
			.p   (prod_s4[k])
		);
	end

	logic [FUNC_W-1:0]    func_s3, func_s4;
	logic [VERDICT_W-1:0] cls_s3, cls_s4;
	logic signed [W-1:0]  d_s3, d_s4;

	always_ff @(posedge clk) begin
		if (adv3) begin
			func_s3 <= func_s2;
			cls_s3  <= cls_s2;
			d_s3    <= d_s2;
		end
		if (adv4) begin
			func_s4 <= func_s3;
			cls_s4  <= cls_s3;
			d_s4    <= d_s3;
		end
	end

	// -- s5: negative-vertex terms and positive-vertex terms
	//    (for a sphere: squares below min and squares above max)
	logic signed [SW-1:0] sa_s5, sb_s5;
	logic signed [PW-1:0] r2_s5;
	logic [FUNC_W-1:0]    func_s5;
	logic [VERDICT_W-1:0] cls_s5;
	logic signed [W-1:0]  d_s5;

	always_ff @(posedge clk) begin
		if (adv5) begin
			sa_s5   <= SW'(prod_s4[0]) + SW'(prod_s4[1]) + SW'(prod_s4[2]);
			sb_s5   <= SW'(prod_s4[AXES]) + SW'(prod_s4[AXES+1])
				+ SW'(prod_s4[AXES+2]);
			r2_s5   <= prod_s4[2*AXES];
			func_s5 <= func_s4;
			cls_s5  <= cls_s4;
			d_s5    <= d_s4;
		end
	end

	// -- s6: offset D in Q32.32, final classification
	logic signed [SW-1:0] dext, dn, dp, tot;
	logic [VERDICT_W-1:0] verdict;
	logic [VERDICT_W-1:0] verdict_s6;

	always_comb begin
		dext = SW'($signed({d_s5, {FRAC_BITS{1'b0}}}));
		dn   = sa_s5 + dext;
		dp   = sb_s5 + dext;
		tot  = sa_s5 + sb_s5;
		case (func_s5)
			FUNC_SPHERE: begin
				verdict = (tot <= SW'(r2_s5)) ? VERDICT_INTERSECTS : VERDICT_DISJOINT;
			end
			FUNC_PLANE: begin
				if (!dn[SW-1] && (dn != '0))
					verdict = VERDICT_PLANE_FRONT;
				else if (dp[SW-1])
					verdict = VERDICT_PLANE_BACK;
				else
					verdict = VERDICT_PLANE_ISECT;
			end
			default: verdict = cls_s5;   // point and box settled in s2
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv6) begin
			verdict_s6 <= verdict;
		end
	end

	assign m_tdata = OUT_TDATA_W'(verdict_s6);

endmodule

// File: src/aabbq_checker.sv
// ----------------------------------------------------------------------------
// AABB query checker
// Port-level checks on stalls, occupancy and result codes; bound to the top.
// ----------------------------------------------------------------------------
`include "aabb_query_unit_macros.svh"

module aabbq_checker import aabbq_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata
);

	localparam logic [2:0] PIPE_DEPTH = 3'd6;

	logic       in_acc, out_acc;
	logic [2:0] cnt_q;   // words taken in, result not yet delivered

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + 3'(in_acc) - 3'(out_acc);
		end
	end

	`AQU_ASSERT_IMP(a_no_phantom, m_tvalid, cnt_q != 3'd0, "result word with no query in flight")
	`AQU_ASSERT_IMP(a_depth, in_acc || !in_acc, cnt_q <= PIPE_DEPTH, "more words in flight than stages")
	`AQU_ASSERT_IMP(a_free_when_empty, !m_tvalid, s_tready, "input stalled with output stage empty")
	`AQU_ASSERT_IMP(a_code, m_tvalid, (m_tdata[2:0] <= VERDICT_PLANE_ISECT) && (m_tdata[7:3] == 5'd0), "bad verdict code")
	`AQU_ASSERT_NXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind aabb_query_unit aabbq_checker u_aabbq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// File: tb/aabb_query_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AABB query unit testbench
// Streams point, box, sphere and plane queries against a series of box
// settings and checks every verdict word against an exact wide-arithmetic
// classifier kept in a small scoreboard. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module aabb_query_unit_tb;
	import aabbq_pkg::*;

	localparam int HOLD_CYCLES  = 300;     // long sink hold-off
	localparam int DRAIN_GUARD  = 12;      // pipeline is 6 deep
	localparam int CYCLE_LIMIT  = 400000;
	localparam int PHASE_WORDS  = 125;

	// query word layout, first_x in the low bits
	typedef struct packed {
		logic [FIELD_W-1:0] scalar;
		logic [FIELD_W-1:0] sz;
		logic [FIELD_W-1:0] sy;
		logic [FIELD_W-1:0] sx;
		logic [FIELD_W-1:0] fz;
		logic [FIELD_W-1:0] fy;
		logic [FIELD_W-1:0] fx;
	} query_data_t;

	// expected verdicts in arrival order, plus a classifier of its own
	class verdict_board;
		logic signed [FIELD_W-1:0] lo [AXES];
		logic signed [FIELD_W-1:0] hi [AXES];
		logic [VERDICT_W-1:0] pending [$];
		int errors;
		int kinds [4];
		int seen [8];

		function new();
			foreach (lo[i]) begin
				lo[i] = '0;
				hi[i] = '0;
			end
			errors = 0;
			foreach (kinds[i]) kinds[i] = 0;
			foreach (seen[i]) seen[i] = 0;
		endfunction

		function void set_bound(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] val);
			case (idx)
			CFG_BOX_MIN_X: lo[0] = val;
			CFG_BOX_MIN_Y: lo[1] = val;
			CFG_BOX_MIN_Z: lo[2] = val;
			CFG_BOX_MAX_X: hi[0] = val;
			CFG_BOX_MAX_Y: hi[1] = val;
			CFG_BOX_MAX_Z: hi[2] = val;
			default: ;
			endcase
		endfunction

		function logic [VERDICT_W-1:0] classify(logic [FUNC_W-1:0] f, query_data_t d);
			logic signed [FIELD_W-1:0] a [AXES];
			logic signed [FIELD_W-1:0] b [AXES];
			logic signed [FIELD_W-1:0] s;
			logic [127:0] acc, rr;
			logic signed [127:0] dn, dp, nw, pw, mw;
			longint dl, sv;
			bit apart, enclosed;
			a[0] = d.fx; a[1] = d.fy; a[2] = d.fz;
			b[0] = d.sx; b[1] = d.sy; b[2] = d.sz;
			s = d.scalar;
			case (f)
			FUNC_POINT: begin
				enclosed = 1'b1;
				for (int i = 0; i < AXES; i++)
					if (a[i] < lo[i] || a[i] > hi[i]) enclosed = 1'b0;
				return enclosed ? VERDICT_CONTAINS : VERDICT_DISJOINT;
			end
			FUNC_BOX: begin
				apart = 1'b0;
				enclosed = 1'b1;
				for (int i = 0; i < AXES; i++) begin
					if (b[i] < lo[i] || a[i] > hi[i]) apart = 1'b1;
					if (a[i] < lo[i] || b[i] > hi[i]) enclosed = 1'b0;
				end
				if (apart) return VERDICT_DISJOINT;
				return enclosed ? VERDICT_CONTAINS : VERDICT_INTERSECTS;
			end
			FUNC_SPHERE: begin
				// squared distance to the box, exact; radius sign is dropped
				acc = '0;
				for (int i = 0; i < AXES; i++) begin
					if (a[i] < lo[i]) begin
						dl = longint'(lo[i]) - longint'(a[i]);
						acc = acc + 128'(dl) * 128'(dl);
					end
					if (a[i] > hi[i]) begin
						dl = longint'(a[i]) - longint'(hi[i]);
						acc = acc + 128'(dl) * 128'(dl);
					end
				end
				sv = s;
				if (sv < 0) sv = -sv;
				rr = 128'(sv) * 128'(sv);
				return (acc <= rr) ? VERDICT_INTERSECTS : VERDICT_DISJOINT;
			end
			default: begin
				// plane distance in Q32.32 at the negative and positive vertices
				dn = s;
				dn = dn <<< FRAC_BITS;
				dp = dn;
				for (int i = 0; i < AXES; i++) begin
					nw = a[i];
					if (a[i] >= 0) begin
						pw = hi[i];
						mw = lo[i];
					end else begin
						pw = lo[i];
						mw = hi[i];
					end
					dn = dn + nw * mw;
					dp = dp + nw * pw;
				end
				if (dn > 0) return VERDICT_PLANE_FRONT;
				if (dp < 0) return VERDICT_PLANE_BACK;
				return VERDICT_PLANE_ISECT;
			end
			endcase
		endfunction

		function void note_query(logic [FUNC_W-1:0] f, query_data_t d);
			kinds[f]++;
			pending.push_back(classify(f, d));
		endfunction

		function void check_verdict(logic [OUT_TDATA_W-1:0] word);
			logic [VERDICT_W-1:0] got, want;
			got = word[VERDICT_W-1:0];
			seen[got]++;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: verdict word %0d with nothing expected", $time, got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				errors++;
				$display("%0t: verdict mismatch: expected %0d, got %0d", $time, want, got);
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [FIELD_W-1:0]     cfg_data;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;  // first_x/y/z, second_x/y/z, scalar
	logic [FUNC_W-1:0]      s_tuser;  // func
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;  // verdict, zero padded

	verdict_board board;
	bit hold_req = 1'b0;     // ask the sink for one long hold-off
	bit calm = 1'b0;         // last part: no idling on either side
	int burst_left = 0;      // words still to send without a gap
	int settings = 0;
	int cycles = 0;
	logic signed [FIELD_W-1:0] box_lo [AXES];
	logic signed [FIELD_W-1:0] box_hi [AXES];

	aabb_query_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// handshake monitor and run watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) board.set_bound(cfg_index, cfg_data);
			if (s_tvalid && s_tready) board.note_query(s_tuser, query_data_t'(s_tdata));
			if (m_tvalid && m_tready) board.check_verdict(m_tdata);
		end
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: run exceeded the cycle limit", $time);
			$display("aabb_query_unit test failed");
			$finish;
		end
	end

	// result sink: random ready bursts, one long hold-off on request
	initial begin
		int n;
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
				hold_req = 1'b0;
			end else if (calm) begin
				m_tready <= 1'b1;
				@(posedge clk);
			end else begin
				case ($urandom_range(0, 9))
				0, 1, 2: m_tready <= 1'b0;
				3:       m_tready <= 1'b1;
				default: m_tready <= 1'b1;
				endcase
				// a burst is cut short once the last part starts
				for (n = $urandom_range(1, 14); n > 0 && !calm; n--) @(posedge clk);
			end
		end
	end

	function automatic logic [FIELD_W-1:0] q16(int v);
		return 32'(v) << FRAC_BITS;
	endfunction

	function automatic query_data_t mk(logic [FIELD_W-1:0] fx, fy, fz, sx, sy, sz, sc);
		query_data_t d;
		d.fx = fx; d.fy = fy; d.fz = fz;
		d.sx = sx; d.sy = sy; d.sz = sz;
		d.scalar = sc;
		return d;
	endfunction

	// corner values get extra weight so every bit and sign is reached
	function automatic logic [FIELD_W-1:0] any_word();
		case ($urandom_range(0, 7))
		0: return 32'h8000_0000;
		1: return 32'h7fff_ffff;
		2: return 32'h0000_0000;
		3: return 32'hffff_ffff;
		default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [FIELD_W-1:0] between(logic signed [FIELD_W-1:0] x, y);
		logic signed [FIELD_W-1:0] l, h;
		logic [63:0] r;
		longint span;
		if (x <= y) begin
			l = x; h = y;
		end else begin
			l = y; h = x;
		end
		span = longint'(h) - longint'(l) + 1;
		r = {$urandom, $urandom};
		return 32'(longint'(l) + longint'(r % 64'(span)));
	endfunction

	function automatic logic signed [FIELD_W-1:0] near(logic signed [FIELD_W-1:0] v);
		return v + 32'($urandom_range(0, 16)) - 32'd8;
	endfunction

	// biased towards the current box so every verdict turns up
	function automatic logic signed [FIELD_W-1:0] pick(int i);
		case ($urandom_range(0, 9))
		0, 1, 2, 3, 4: return between(box_lo[i], box_hi[i]);
		5, 6: return near(box_lo[i]);
		7: return near(box_hi[i]);
		default: return any_word();
		endcase
	endfunction

	task automatic make_query(output logic [FUNC_W-1:0] f, output query_data_t d);
		logic signed [FIELD_W-1:0] a [AXES];
		logic signed [FIELD_W-1:0] b [AXES];
		logic signed [FIELD_W-1:0] t, sc;
		logic signed [127:0] acc;
		f = FUNC_W'($urandom_range(0, 3));
		for (int i = 0; i < AXES; i++) begin
			a[i] = pick(i);
			b[i] = any_word();
		end
		sc = any_word();
		case (f)
		FUNC_BOX: begin
			for (int i = 0; i < AXES; i++) b[i] = pick(i);
			// mostly well-ordered query boxes, some left inverted
			if ($urandom_range(0, 9) < 8)
				for (int i = 0; i < AXES; i++)
					if (a[i] > b[i]) begin
						t = a[i]; a[i] = b[i]; b[i] = t;
					end
		end
		FUNC_SPHERE: begin
			if ($urandom_range(0, 2) != 0) begin
				sc = $urandom >> $urandom_range(0, 31);
				if ($urandom_range(0, 3) == 0) sc = -sc;
			end
		end
		FUNC_PLANE: begin
			// unit-scale normal through a point of the box, offset jittered
			if ($urandom_range(0, 9) < 6) begin
				acc = '0;
				for (int i = 0; i < AXES; i++) begin
					a[i] = 32'(int'($urandom_range(0, 131072)) - 65536);
					if ($urandom_range(0, 4) == 0) a[i] = '0;
					acc = acc + 128'(a[i]) * 128'(between(box_lo[i], box_hi[i]));
				end
				sc = near(32'(-(acc >>> FRAC_BITS)));
			end
		end
		default: ;
		endcase
		d = mk(a[0], a[1], a[2], b[0], b[1], b[2], sc);
	endtask

	// valid stays up across back-to-back words; a gap lowers it first
	task automatic send_query(logic [FUNC_W-1:0] f, query_data_t d);
		s_tuser <= f;
		s_tdata <= d;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic idle_input(int n);
		s_tvalid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// stop sending and wait for every outstanding verdict
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_GUARD) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] v);
		cfg_index <= idx;
		cfg_data <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic write_box(logic [FIELD_W-1:0] lx, ly, lz, hx, hy, hz);
		write_reg(CFG_BOX_MIN_X, lx);
		write_reg(CFG_BOX_MIN_Y, ly);
		write_reg(CFG_BOX_MIN_Z, lz);
		write_reg(CFG_BOX_MAX_X, hx);
		write_reg(CFG_BOX_MAX_Y, hy);
		write_reg(CFG_BOX_MAX_Z, hz);
		cfg_valid <= 1'b0;
		@(posedge clk);
		box_lo[0] = lx; box_lo[1] = ly; box_lo[2] = lz;
		box_hi[0] = hx; box_hi[1] = hy; box_hi[2] = hz;
		settings++;
	endtask

	task automatic run_phase(int n, bit hold, bit pause);
		logic [FUNC_W-1:0] f;
		query_data_t d;
		for (int k = 0; k < n; k++) begin
			if (k == n / 2) begin
				if (hold) begin
					hold_req = 1'b1;
					burst_left = 40;
				end
				if (pause) drain_results();
			end
			if (burst_left > 0) begin
				burst_left--;
			end else if (!calm) begin
				if ($urandom_range(0, 19) == 0)
					burst_left = $urandom_range(10, 30);
				else if ($urandom_range(0, 3) == 0)
					idle_input($urandom_range(1, 14));
			end
			make_query(f, d);
			send_query(f, d);
		end
		drain_results();
	endtask

	initial begin
		logic signed [FIELD_W-1:0] lo [AXES];
		logic signed [FIELD_W-1:0] hi [AXES];
		logic signed [FIELD_W-1:0] t;
		int total;
		board = new();
		foreach (box_lo[i]) begin
			box_lo[i] = '0;
			box_hi[i] = '0;
		end
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_BOX_MIN_X;
		cfg_data <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= FUNC_POINT;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset box is the single point at the origin
		send_query(FUNC_POINT, mk(0, 0, 0, $urandom, $urandom, $urandom, $urandom));
		send_query(FUNC_BOX, mk(0, 0, 0, 0, 0, 0, $urandom));
		drain_results();

		write_box(q16(-10), q16(-20), q16(-30), q16(10), q16(20), q16(30));
		// points: both corners, just outside, extremes; unused fields random or zero
		send_query(FUNC_POINT, mk(q16(-10), q16(-20), q16(-30),
			$urandom, $urandom, $urandom, $urandom));
		send_query(FUNC_POINT, mk(q16(10), q16(20), q16(30),
			$urandom, $urandom, $urandom, $urandom));
		send_query(FUNC_POINT, mk(q16(10) + 1, 0, 0, $urandom, $urandom, $urandom, $urandom));
		send_query(FUNC_POINT, mk(32'h8000_0000, 32'h7fff_ffff, 0, 0, 0, 0, 0));
		// boxes: inside, equal, overlapping, apart, enclosing, inverted, extremes
		send_query(FUNC_BOX, mk(q16(-1), q16(-1), q16(-1), q16(1), q16(1), q16(1), $urandom));
		send_query(FUNC_BOX, mk(q16(-10), q16(-20), q16(-30), q16(10), q16(20), q16(30), 0));
		send_query(FUNC_BOX, mk(q16(5), q16(5), q16(5), q16(50), q16(50), q16(50), 0));
		send_query(FUNC_BOX, mk(q16(11), 0, 0, q16(12), q16(1), q16(1), 0));
		send_query(FUNC_BOX, mk(q16(-100), q16(-100), q16(-100),
			q16(100), q16(100), q16(100), 0));
		send_query(FUNC_BOX, mk(q16(5), q16(5), q16(5), q16(-5), q16(-5), q16(-5), 0));
		send_query(FUNC_BOX, mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff));
		// spheres: zero radius, just touching, just short, negative radius, extremes
		send_query(FUNC_SPHERE, mk(0, 0, 0, $urandom, $urandom, $urandom, 0));
		send_query(FUNC_SPHERE, mk(q16(15), 0, 0, 0, 0, 0, q16(5)));
		send_query(FUNC_SPHERE, mk(q16(15), 0, 0, 0, 0, 0, q16(5) - 1));
		send_query(FUNC_SPHERE, mk(q16(15), 0, 0, 0, 0, 0, q16(-5)));
		send_query(FUNC_SPHERE, mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			0, 0, 0, 32'h8000_0000));
		send_query(FUNC_SPHERE, mk(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			0, 0, 0, 32'h7fff_ffff));
		// planes: zero normal, front, back, touching, negative normal, extremes
		send_query(FUNC_PLANE, mk(0, 0, 0, $urandom, $urandom, $urandom, 0));
		send_query(FUNC_PLANE, mk(q16(1), 0, 0, 0, 0, 0, q16(20)));
		send_query(FUNC_PLANE, mk(q16(1), 0, 0, 0, 0, 0, q16(-20)));
		send_query(FUNC_PLANE, mk(0, q16(1), 0, 0, 0, 0, q16(-20)));
		send_query(FUNC_PLANE, mk(q16(-1), 0, 0, 0, 0, 0, q16(10)));
		send_query(FUNC_PLANE, mk(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
			0, 0, 0, 32'h7fff_ffff));
		drain_results();

		// modest ordered box, with the long sink hold-off
		for (int i = 0; i < AXES; i++) begin
			lo[i] = -32'($urandom_range(1, 1 << 24));
			hi[i] = 32'($urandom_range(1, 1 << 24));
		end
		write_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
		run_phase(PHASE_WORDS, 1'b1, 1'b0);

		// widest box the registers hold
		write_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		run_phase(PHASE_WORDS, 1'b0, 1'b1);

		// inverted on some axes: comparisons run unchanged
		for (int i = 0; i < AXES; i++) begin
			lo[i] = $urandom;
			hi[i] = $urandom;
			if (lo[i] < hi[i] && $urandom_range(0, 2) != 0) begin
				t = lo[i]; lo[i] = hi[i]; hi[i] = t;
			end
		end
		write_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
		run_phase(PHASE_WORDS, 1'b0, 1'b0);

		// flat box, min equal to max
		for (int i = 0; i < AXES; i++) begin
			lo[i] = 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
			hi[i] = lo[i];
		end
		write_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
		run_phase(PHASE_WORDS, 1'b1, 1'b1);

		// random bounds, corner words included
		for (int i = 0; i < AXES; i++) begin
			lo[i] = any_word();
			hi[i] = any_word();
			if (lo[i] > hi[i] && $urandom_range(0, 1) == 0) begin
				t = lo[i]; lo[i] = hi[i]; hi[i] = t;
			end
		end
		write_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
		run_phase(PHASE_WORDS, 1'b0, 1'b0);

		// last part: small box, full rate both sides
		calm = 1'b1;
		for (int i = 0; i < AXES; i++) begin
			lo[i] = -32'($urandom_range(0, 1 << 18));
			hi[i] = 32'($urandom_range(0, 1 << 18));
		end
		write_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
		run_phase(PHASE_WORDS, 1'b0, 1'b0);

		if (board.pending.size() != 0)
			$display("%0t: %0d expected verdicts never arrived", $time, board.pending.size());
		total = board.kinds[0] + board.kinds[1] + board.kinds[2] + board.kinds[3];
		$display("Covered %0d queries (point %0d, box %0d, sphere %0d, plane %0d)",
			total, board.kinds[FUNC_POINT], board.kinds[FUNC_BOX],
			board.kinds[FUNC_SPHERE], board.kinds[FUNC_PLANE]);
		$display("over %0d boxes; verdicts: disjoint %0d, contains %0d, intersects %0d,",
			settings + 1, board.seen[VERDICT_DISJOINT], board.seen[VERDICT_CONTAINS],
			board.seen[VERDICT_INTERSECTS]);
		$display("front %0d, back %0d, crossing %0d.",
			board.seen[VERDICT_PLANE_FRONT], board.seen[VERDICT_PLANE_BACK],
			board.seen[VERDICT_PLANE_ISECT]);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("aabb_query_unit test passed");
		else
			$display("aabb_query_unit test failed");
		$finish;
	end

endmodule
